// ===== design/swm_pkg.sv =====
package swm_pkg;

  localparam int unsigned MAX_WINDOW_DEF = 64;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned POS_W          = 32;
  localparam int unsigned CFG_W          = 7;
  localparam logic [CFG_W-1:0] WL_RESET  = CFG_W'(3);

  typedef struct packed {
    logic load_in;
    logic rd_en;
    logic rd_tail;
    logic pop_head;
    logic pop_tail;
    logic append;
    logic load_out;
  } swm_cmd_t;

  typedef struct packed {
    logic occ_zero;
    logic occ_full;
    logic expired;
    logic greater;
    logic emit;
    logic out_free;
  } swm_sts_t;

endpackage

// ===== design/swm_ram.sv =====
module swm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/swm_ctrl.sv =====
module swm_ctrl
  import swm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  swm_sts_t sts,
  output swm_cmd_t cmd
);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_EXP_RD  = 8'b0000_0010,
    ST_EXP_CMP = 8'b0000_0100,
    ST_DRP_RD  = 8'b0000_1000,
    ST_DRP_CMP = 8'b0001_0000,
    ST_APPEND  = 8'b0010_0000,
    ST_OUT_RD  = 8'b0100_0000,
    ST_OUT_LD  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_EXP_RD;
        end
      end
      ST_EXP_RD: begin
        if (sts.occ_zero) begin
          state_nxt = ST_DRP_RD;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_EXP_CMP;
        end
      end
      ST_EXP_CMP: begin
        if (sts.expired) begin
          cmd.pop_head = 1'b1;
          state_nxt    = ST_EXP_RD;
        end else begin
          state_nxt = ST_DRP_RD;
        end
      end
      ST_DRP_RD: begin
        if (sts.occ_zero) begin
          state_nxt = ST_APPEND;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_tail = 1'b1;
          state_nxt   = ST_DRP_CMP;
        end
      end
      ST_DRP_CMP: begin
        if (sts.greater) begin
          state_nxt = ST_APPEND;
        end else begin
          cmd.pop_tail = 1'b1;
          state_nxt    = ST_DRP_RD;
        end
      end
      ST_APPEND: begin
        cmd.append   = 1'b1;
        cmd.pop_head = sts.occ_full;
        state_nxt    = sts.emit ? ST_OUT_RD : ST_IDLE;
      end
      ST_OUT_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/swm_dp.sv =====
module swm_dp
  import swm_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_window_length,
  input  logic signed [DATA_W-1:0] in_sample,
  input  logic                     in_first,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_window_max,
  input  swm_cmd_t                 cmd,
  output swm_sts_t                 sts
);

  localparam int unsigned PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned OCC_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned MEM_W = DATA_W + POS_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_WINDOW - 1);

  logic [PTR_W-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [POS_W-1:0]  seen_r, seen_nxt;
  logic [DATA_W-1:0] x_r;
  logic [CFG_W-1:0]  wl_r;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r;

  logic [PTR_W-1:0]  head_next, tail_next, tail_prev, rd_addr;
  logic [MEM_W-1:0]  rd_data;
  logic [DATA_W-1:0] rd_val;
  logic [POS_W-1:0]  rd_pos, win, seen_inc;

  assign head_next = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
  assign tail_next = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
  assign tail_prev = (tail_r == '0) ? PTR_LAST : tail_r - PTR_W'(1);
  assign rd_addr   = cmd.rd_tail ? tail_prev : head_r;

  swm_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (tail_r),
    .wdata ({x_r, seen_r}),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign rd_val   = rd_data[MEM_W-1:POS_W];
  assign rd_pos   = rd_data[POS_W-1:0];
  assign seen_inc = seen_r + POS_W'(1);

  always_comb begin
    if (wl_r == '0) begin
      win = POS_W'(1);
    end else if (POS_W'(wl_r) > POS_W'(MAX_WINDOW)) begin
      win = POS_W'(MAX_WINDOW);
    end else begin
      win = POS_W'(wl_r);
    end
  end

  assign sts.occ_zero = (occ_r == '0);
  assign sts.occ_full = (occ_r == OCC_W'(MAX_WINDOW));
  assign sts.expired  = ((seen_r - rd_pos) >= win);
  assign sts.greater  = ($signed(rd_val) > $signed(x_r));
  assign sts.emit     = (seen_inc >= win);
  assign sts.out_free = !out_valid_r || !out_stall;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    occ_nxt  = occ_r;
    seen_nxt = seen_r;
    if (cmd.load_in && in_first) begin
      head_nxt = '0;
      tail_nxt = '0;
      occ_nxt  = '0;
      seen_nxt = '0;
    end
    if (cmd.pop_head) begin
      head_nxt = head_next;
    end
    if (cmd.pop_tail) begin
      tail_nxt = tail_prev;
    end
    if (cmd.append) begin
      tail_nxt = tail_next;
      seen_nxt = seen_inc;
    end
    priority if (cmd.append && !cmd.pop_head) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (!cmd.append && (cmd.pop_head || cmd.pop_tail)) begin
      occ_nxt = occ_r - OCC_W'(1);
    end else begin
      occ_nxt = occ_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      seen_r      <= '0;
      wl_r        <= WL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        wl_r <= cfg_window_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r <= in_sample;
    end
    if (cmd.load_out) begin
      out_data_r <= rd_val;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_window_max = out_data_r;

endmodule

// ===== design/sliding_window_maximum_unit.sv =====
// One sample at a time; in_stall is high from the accepting edge until the item is done.
// Each item is accepted, then runs an expiry pass (pops expired head entries) and a drop pass
// (pops tail entries not greater than the sample) before it is appended. A result, if due, is then
// read and loaded, waiting while the previous one is stalled; the single RAM read port sets the
// pass length. A result is valid the cycle after the item ends and held until taken.
// Synchronous active-low reset empties the queue, clears count and out_valid, window_length = 3.
module sliding_window_maximum_unit
  import swm_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_sample,
  input  logic                     in_first,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_window_max,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_W-1:0]         cfg_window_length
);

  swm_cmd_t cmd;
  swm_sts_t sts;

  assign cfg_ready = 1'b1;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  swm_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_valid),
    .cfg_window_length (cfg_window_length),
    .in_sample         (in_sample),
    .in_first          (in_first),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_window_max    (out_window_max),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

// ===== design/swm_checker.sv =====
module swm_checker
  import swm_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] out_window_max
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_window_max))
    else $error("result changed or dropped while stalled");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transfer");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no item in progress");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("bad state after reset");

endmodule

bind sliding_window_maximum_unit swm_checker u_swm_checker (.*);
